>>> design/uehl_pkg.sv
package uehl_pkg;

   localparam int THR_BITS     = 7;
   localparam int WGT_BITS     = 9;
   localparam int CSR_IDX_BITS = 3;
   localparam int PCT_SCALE    = 100;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UP_TO_MID          = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UP_TO_WARNING      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UP_TO_CRITICAL     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DOWN_FROM_CRITICAL = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DOWN_FROM_WARNING  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DOWN_FROM_MID      = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SMOOTHING_WEIGHT   = 3'd6;

   localparam logic [1:0] LVL_DEFAULT  = 2'd0;
   localparam logic [1:0] LVL_MID      = 2'd1;
   localparam logic [1:0] LVL_WARNING  = 2'd2;
   localparam logic [1:0] LVL_CRITICAL = 2'd3;

   typedef struct packed {
      logic [THR_BITS-1:0] up_to_mid;
      logic [THR_BITS-1:0] up_to_warning;
      logic [THR_BITS-1:0] up_to_critical;
      logic [THR_BITS-1:0] down_from_critical;
      logic [THR_BITS-1:0] down_from_warning;
      logic [THR_BITS-1:0] down_from_mid;
      logic [WGT_BITS-1:0] smoothing_weight;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      up_to_mid:          7'd30,
      up_to_warning:      7'd65,
      up_to_critical:     7'd85,
      down_from_critical: 7'd75,
      down_from_warning:  7'd55,
      down_from_mid:      7'd20,
      smoothing_weight:   9'd64
   };

endpackage

>>> design/uehl_front.sv
module uehl_front #(
   parameter int COUNTER_BITS = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [COUNTER_BITS-1:0]    req_user_ticks,
   input  logic [COUNTER_BITS-1:0]    req_nice_ticks,
   input  logic [COUNTER_BITS-1:0]    req_system_ticks,
   input  logic [COUNTER_BITS-1:0]    req_idle_ticks,
   input  logic [COUNTER_BITS-1:0]    req_iowait_ticks,
   input  logic [COUNTER_BITS-1:0]    req_irq_ticks,
   input  logic [COUNTER_BITS-1:0]    req_softirq_ticks,
   input  logic [COUNTER_BITS-1:0]    req_steal_ticks,
   input  logic                       req_force_report,
   output logic                       push,
   output logic [2*COUNTER_BITS+6:0]  push_data,
   input  logic                       full
);
   import uehl_pkg::*;

   localparam int TW = COUNTER_BITS + 3;
   localparam int IW = COUNTER_BITS + 1;

   logic          stg_vld_ff, stg_vld_in;
   logic          primed_ff, primed_in;
   logic [TW-1:0] tot_ff, prior_tot_ff, prior_tot_in;
   logic [IW-1:0] idl_ff, prior_idl_ff, prior_idl_in;
   logic          frc_ff;
   logic [TW-1:0] tot_sum;
   logic [IW-1:0] idl_sum;
   logic [TW-1:0] dt;
   logic [IW-1:0] di;
   logic [TW-1:0] di_wide;
   logic          idle_over;
   logic          keep;
   logic          drain;
   logic          accept;

   assign tot_sum = TW'(req_user_ticks) + TW'(req_nice_ticks) + TW'(req_system_ticks)
                  + TW'(req_idle_ticks) + TW'(req_iowait_ticks) + TW'(req_irq_ticks)
                  + TW'(req_softirq_ticks) + TW'(req_steal_ticks);
   assign idl_sum = IW'(req_idle_ticks) + IW'(req_iowait_ticks);

   // deltas wrap modulo the width of each sum
   assign dt        = tot_ff - prior_tot_ff;
   assign di        = idl_ff - prior_idl_ff;
   assign di_wide   = TW'(di);
   assign idle_over = di_wide > dt;
   assign keep      = primed_ff && (dt != '0);

   assign drain     = stg_vld_ff && (!keep || !full);
   assign push      = stg_vld_ff && keep && !full;
   assign push_data = {frc_ff, (idle_over ? '0 : dt - di_wide), dt};
   assign req_ready = !stg_vld_ff || drain;
   assign accept    = req_valid && req_ready;

   always_comb begin
      stg_vld_in   = stg_vld_ff;
      primed_in    = primed_ff;
      prior_tot_in = prior_tot_ff;
      prior_idl_in = prior_idl_ff;
      if (drain) begin
         stg_vld_in   = 1'b0;
         primed_in    = 1'b1;
         prior_tot_in = tot_ff;
         prior_idl_in = idl_ff;
      end
      if (accept) begin
         stg_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff   <= 1'b0;
         primed_ff    <= 1'b0;
         prior_tot_ff <= '0;
         prior_idl_ff <= '0;
      end else begin
         stg_vld_ff   <= stg_vld_in;
         primed_ff    <= primed_in;
         prior_tot_ff <= prior_tot_in;
         prior_idl_ff <= prior_idl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tot_ff <= tot_sum;
         idl_ff <= idl_sum;
         frc_ff <= req_force_report;
      end
   end

endmodule

>>> design/uehl_fifo.sv
module uehl_fifo #(
   parameter int WIDTH = 103
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import uehl_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/uehl_back.sv
module uehl_back #(
   parameter int COUNTER_BITS = 48,
   parameter int FRAC_BITS    = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  uehl_pkg::cfg_type          cfg,
   output logic                       pop,
   input  logic [2*COUNTER_BITS+6:0]  pop_data,
   input  logic                       empty,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [FRAC_BITS+6:0]       rsp_smoothed_busy,
   output logic [1:0]                 rsp_load_level
);
   import uehl_pkg::*;

   localparam int TW = COUNTER_BITS + 3;
   localparam int QW = 7 + FRAC_BITS;
   localparam int PW = WGT_BITS + QW;
   localparam int SW = PW + 1;
   localparam int CW = $clog2(QW + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_AVG  = 5'b01000,
      ST_LVL  = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [TW-1:0]       d_ff, r_ff;
   logic [QW-1:0]       lo_ff, q_ff;
   logic [CW-1:0]       cnt_ff;
   logic                frc_ff;
   logic [PW-1:0]       p1_ff, p2_ff;
   logic                avg_valid_ff, avg_valid_in;
   logic [QW-1:0]       avg_ff, avg_in;
   logic [1:0]          level_ff, level_in;
   logic                rep_once_ff, rep_once_in;
   logic [1:0]          rep_level_ff, rep_level_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [QW-1:0]       busy_out_ff;
   logic [1:0]          lvl_out_ff;

   logic [TW-1:0]       pop_d, pop_n;
   logic [TW+6:0]       n_wide, m;
   logic [TW:0]         r2;
   logic                ge;
   logic [TW:0]         r_sub;
   logic [WGT_BITS-1:0] w_eff, w_cmp;
   logic [SW-1:0]       ema_sum;
   logic [1:0]          level_nxt;
   logic                report;
   logic                out_free;
   logic                out_set;

   function automatic logic [QW-1:0] pct(input logic [THR_BITS-1:0] t);
      return {t, {FRAC_BITS{1'b0}}};
   endfunction

   function automatic logic [1:0] next_level(input logic [1:0] lvl, input logic [QW-1:0] a,
                                             input cfg_type c);
      logic [1:0] res;
      res = lvl;
      unique case (lvl)
         LVL_DEFAULT: begin
            if (a > pct(c.up_to_mid)) res = LVL_MID;
         end
         LVL_MID: begin
            if (a > pct(c.up_to_warning)) res = LVL_WARNING;
            else if (a < pct(c.down_from_mid)) res = LVL_DEFAULT;
         end
         LVL_WARNING: begin
            if (a > pct(c.up_to_critical)) res = LVL_CRITICAL;
            else if (a < pct(c.down_from_warning)) res = LVL_MID;
         end
         default: begin
            if (a < pct(c.down_from_critical)) res = LVL_WARNING;
         end
      endcase
      return res;
   endfunction

   assign pop    = (state_ff == ST_IDLE) && !empty;
   assign pop_d  = pop_data[TW-1:0];
   assign pop_n  = pop_data[2*TW-1:TW];

   // n*100 as shifts and adds; top bits seed the remainder, which stays below d
   assign n_wide = (TW+7)'(pop_n);
   assign m      = (n_wide << 6) + (n_wide << 5) + (n_wide << 2);

   // restoring divider, one quotient bit per cycle
   assign r2    = {r_ff, lo_ff[QW-1]};
   assign ge    = r2 >= {1'b0, d_ff};
   assign r_sub = r2 - {1'b0, d_ff};

   // weight 0 acts as 1, anything above 256 acts as 256
   always_comb begin
      w_eff = cfg.smoothing_weight;
      if (cfg.smoothing_weight == '0) begin
         w_eff = WGT_BITS'(1);
      end else if (cfg.smoothing_weight[WGT_BITS-1] && (cfg.smoothing_weight[WGT_BITS-2:0] != '0)) begin
         w_eff = WGT_BITS'(256);
      end
   end
   assign w_cmp = WGT_BITS'(256) - w_eff;

   assign ema_sum = SW'(p1_ff) + SW'(p2_ff) + SW'(128);

   assign level_nxt = next_level(level_ff, avg_ff, cfg);
   assign report    = frc_ff || !rep_once_ff || (level_nxt != rep_level_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_set   = (state_ff == ST_LVL) && report && out_free;

   always_comb begin
      state_in     = state_ff;
      avg_valid_in = avg_valid_ff;
      avg_in       = avg_ff;
      level_in     = level_ff;
      rep_once_in  = rep_once_ff;
      rep_level_in = rep_level_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CW'(1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_AVG;
         end
         ST_AVG: begin
            avg_valid_in = 1'b1;
            avg_in       = avg_valid_ff ? ema_sum[QW+7:8] : q_ff;
            state_in     = ST_LVL;
         end
         ST_LVL: begin
            if (!report || out_free) begin
               level_in = level_nxt;
               state_in = ST_IDLE;
               if (report) begin
                  rep_once_in  = 1'b1;
                  rep_level_in = level_nxt;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (out_set) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_valid_ff <= 1'b0;
         avg_ff       <= '0;
         level_ff     <= LVL_DEFAULT;
         rep_once_ff  <= 1'b0;
         rep_level_ff <= LVL_DEFAULT;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         avg_valid_ff <= avg_valid_in;
         avg_ff       <= avg_in;
         level_ff     <= level_in;
         rep_once_ff  <= rep_once_in;
         rep_level_ff <= rep_level_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            cnt_ff <= CW'(QW);
         end else if (state_ff == ST_DIV) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         d_ff   <= pop_d;
         r_ff   <= m[TW+6:7];
         lo_ff  <= {m[6:0], {FRAC_BITS{1'b0}}};
         q_ff   <= '0;
         frc_ff <= pop_data[2*TW];
      end else if (state_ff == ST_DIV) begin
         r_ff  <= ge ? r_sub[TW-1:0] : r2[TW-1:0];
         lo_ff <= {lo_ff[QW-2:0], 1'b0};
         q_ff  <= {q_ff[QW-2:0], ge};
      end
      if (state_ff == ST_MUL) begin
         p1_ff <= PW'(w_eff) * PW'(q_ff);
         p2_ff <= PW'(w_cmp) * PW'(avg_ff);
      end
      if (out_set) begin
         busy_out_ff <= avg_ff;
         lvl_out_ff  <= level_nxt;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_smoothed_busy = busy_out_ff;
   assign rsp_load_level    = lvl_out_ff;

endmodule

>>> design/utilization_ema_hysteresis_level.sv
// CPU utilization monitor: each sample of eight cumulative tick counters gives a busy
// percent (FRAC_BITS fraction bits) from the deltas against the previous sample, smoothed
// by an EMA and classified into four load levels with hysteresis. The first sample only
// primes the block and a sample with no elapsed ticks gives no result; otherwise a result
// appears on the first valid sample, on a level change, or when force_report is set. The
// front registers the sums of a sample, then forms its deltas against the previous sample
// and hands them to the back through a two-entry queue. The back takes one sample at a
// time through divide, multiply, average and level states; its restoring divider yields
// one quotient bit per cycle; a finished result sits in an output register while further samples flow in.
// Registers are written through the csr_ port (index 0..6, other indexes ignored).
module utilization_ema_hysteresis_level #(
   parameter int COUNTER_BITS = 48,
   parameter int FRAC_BITS    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [uehl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [uehl_pkg::WGT_BITS-1:0]        csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [COUNTER_BITS-1:0]              req_user_ticks,
   input  logic [COUNTER_BITS-1:0]              req_nice_ticks,
   input  logic [COUNTER_BITS-1:0]              req_system_ticks,
   input  logic [COUNTER_BITS-1:0]              req_idle_ticks,
   input  logic [COUNTER_BITS-1:0]              req_iowait_ticks,
   input  logic [COUNTER_BITS-1:0]              req_irq_ticks,
   input  logic [COUNTER_BITS-1:0]              req_softirq_ticks,
   input  logic [COUNTER_BITS-1:0]              req_steal_ticks,
   input  logic                                 req_force_report,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [FRAC_BITS+6:0]                 rsp_smoothed_busy,
   output logic [1:0]                           rsp_load_level
);
   import uehl_pkg::*;

   localparam int QUEUE_W = 2 * (COUNTER_BITS + 3) + 1;

   cfg_type              cfg_ff, cfg_in;
   logic                 q_push, q_full, q_pop, q_empty;
   logic [QUEUE_W-1:0]   q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UP_TO_MID:          cfg_in.up_to_mid          = csr_data[THR_BITS-1:0];
            CSR_UP_TO_WARNING:      cfg_in.up_to_warning      = csr_data[THR_BITS-1:0];
            CSR_UP_TO_CRITICAL:     cfg_in.up_to_critical     = csr_data[THR_BITS-1:0];
            CSR_DOWN_FROM_CRITICAL: cfg_in.down_from_critical = csr_data[THR_BITS-1:0];
            CSR_DOWN_FROM_WARNING:  cfg_in.down_from_warning  = csr_data[THR_BITS-1:0];
            CSR_DOWN_FROM_MID:      cfg_in.down_from_mid      = csr_data[THR_BITS-1:0];
            CSR_SMOOTHING_WEIGHT:   cfg_in.smoothing_weight   = csr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uehl_front #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_user_ticks    (req_user_ticks),
      .req_nice_ticks    (req_nice_ticks),
      .req_system_ticks  (req_system_ticks),
      .req_idle_ticks    (req_idle_ticks),
      .req_iowait_ticks  (req_iowait_ticks),
      .req_irq_ticks     (req_irq_ticks),
      .req_softirq_ticks (req_softirq_ticks),
      .req_steal_ticks   (req_steal_ticks),
      .req_force_report  (req_force_report),
      .push              (q_push),
      .push_data         (q_wdata),
      .full              (q_full)
   );

   uehl_fifo #(
      .WIDTH(QUEUE_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   uehl_back #(
      .COUNTER_BITS(COUNTER_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop               (q_pop),
      .pop_data          (q_rdata),
      .empty             (q_empty),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_smoothed_busy (rsp_smoothed_busy),
      .rsp_load_level    (rsp_load_level)
   );

   a_busy_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_smoothed_busy <= {7'(PCT_SCALE), {FRAC_BITS{1'b0}}}))
      else $error("smoothed busy above one hundred percent");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue read while empty");

endmodule

>>> tb/uehl_checker.sv
module uehl_checker #(
   parameter int COUNTER_BITS = 48,
   parameter int FRAC_BITS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [uehl_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [uehl_pkg::WGT_BITS-1:0]     csr_data,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [COUNTER_BITS-1:0]           req_user_ticks,
   input  logic [COUNTER_BITS-1:0]           req_nice_ticks,
   input  logic [COUNTER_BITS-1:0]           req_system_ticks,
   input  logic [COUNTER_BITS-1:0]           req_idle_ticks,
   input  logic [COUNTER_BITS-1:0]           req_iowait_ticks,
   input  logic [COUNTER_BITS-1:0]           req_irq_ticks,
   input  logic [COUNTER_BITS-1:0]           req_softirq_ticks,
   input  logic [COUNTER_BITS-1:0]           req_steal_ticks,
   input  logic                              req_force_report,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [FRAC_BITS+6:0]              rsp_smoothed_busy,
   input  logic [1:0]                        rsp_load_level,
   output int                                error_count,
   output int                                pending_count
);
   import uehl_pkg::*;

   localparam int TOT_W  = COUNTER_BITS + 3;
   localparam int IDL_W  = COUNTER_BITS + 1;
   localparam int AVG_W  = FRAC_BITS + 7;
   localparam int PROD_W = TOT_W + AVG_W;
   localparam logic [AVG_W-1:0] FULL_SCALE = AVG_W'(PCT_SCALE << FRAC_BITS);

   typedef struct packed {
      logic [AVG_W-1:0] busy;
      logic [1:0]       level;
   } report_type;

   cfg_type          cfg;
   logic             primed;
   logic             avg_valid;
   logic             reported;
   logic [TOT_W-1:0] last_total;
   logic [IDL_W-1:0] last_idle;
   logic [AVG_W-1:0] avg_busy;
   logic [1:0]       level;
   logic [1:0]       reported_level;
   logic [TOT_W-1:0] sum_total;
   logic [IDL_W-1:0] sum_idle;
   report_type       want;
   report_type       reports_due[$];
   int               mismatches = 0;

   function automatic int pct(input logic [THR_BITS-1:0] t);
      return int'(t) << FRAC_BITS;
   endfunction

   // one step of the hysteresis ladder
   function automatic logic [1:0] step_level(input logic [1:0] lvl, input int a);
      case (lvl)
         LVL_DEFAULT: return (a > pct(cfg.up_to_mid)) ? LVL_MID : LVL_DEFAULT;
         LVL_MID: begin
            if (a > pct(cfg.up_to_warning)) return LVL_WARNING;
            if (a < pct(cfg.down_from_mid)) return LVL_DEFAULT;
            return LVL_MID;
         end
         LVL_WARNING: begin
            if (a > pct(cfg.up_to_critical)) return LVL_CRITICAL;
            if (a < pct(cfg.down_from_warning)) return LVL_MID;
            return LVL_WARNING;
         end
         default: return (a < pct(cfg.down_from_critical)) ? LVL_WARNING : LVL_CRITICAL;
      endcase
   endfunction

   task automatic track_sample(input logic [TOT_W-1:0] tot, input logic [IDL_W-1:0] idl,
                               input logic frc);
      logic [TOT_W-1:0]  dt;
      logic [IDL_W-1:0]  di;
      logic [PROD_W-1:0] scaled;
      int                raw;
      int                w;
      int                blend;
      report_type        rep;
      if (!primed) begin
         primed     = 1'b1;
         last_total = tot;
         last_idle  = idl;
      end else begin
         // deltas wrap at the width of each sum
         dt         = tot - last_total;
         di         = idl - last_idle;
         last_total = tot;
         last_idle  = idl;
         if (dt != 0) begin
            if (TOT_W'(di) > dt) begin
               raw = 0;
            end else begin
               scaled = PROD_W'(dt - TOT_W'(di)) * PROD_W'(FULL_SCALE);
               scaled = scaled / PROD_W'(dt);
               raw    = int'(scaled[AVG_W-1:0]);
            end
            w = int'(cfg.smoothing_weight);
            if (w == 0) begin
               w = 1;
            end else if (w > 256) begin
               w = 256;
            end
            if (!avg_valid) begin
               avg_busy  = raw[AVG_W-1:0];
               avg_valid = 1'b1;
            end else begin
               blend    = (w * raw + (256 - w) * int'(avg_busy) + 128) >> 8;
               avg_busy = blend[AVG_W-1:0];
            end
            level = step_level(level, int'(avg_busy));
            if (frc || !reported || level != reported_level) begin
               reported       = 1'b1;
               reported_level = level;
               rep.busy       = avg_busy;
               rep.level      = level;
               reports_due.push_back(rep);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg            = CFG_RESET;
         primed         = 1'b0;
         avg_valid      = 1'b0;
         reported       = 1'b0;
         last_total     = '0;
         last_idle      = '0;
         avg_busy       = '0;
         level          = LVL_DEFAULT;
         reported_level = LVL_DEFAULT;
         reports_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_UP_TO_MID:          cfg.up_to_mid          = csr_data[THR_BITS-1:0];
               CSR_UP_TO_WARNING:      cfg.up_to_warning      = csr_data[THR_BITS-1:0];
               CSR_UP_TO_CRITICAL:     cfg.up_to_critical     = csr_data[THR_BITS-1:0];
               CSR_DOWN_FROM_CRITICAL: cfg.down_from_critical = csr_data[THR_BITS-1:0];
               CSR_DOWN_FROM_WARNING:  cfg.down_from_warning  = csr_data[THR_BITS-1:0];
               CSR_DOWN_FROM_MID:      cfg.down_from_mid      = csr_data[THR_BITS-1:0];
               CSR_SMOOTHING_WEIGHT:   cfg.smoothing_weight   = csr_data;
               default: ;
            endcase
         end
         // compare before predicting: a result never belongs to a sample of the same edge
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: busy %0d level %0d",
                           rsp_smoothed_busy, rsp_load_level);
            end else begin
               want = reports_due.pop_front();
               if (want.busy !== rsp_smoothed_busy || want.level !== rsp_load_level) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: busy exp %0d got %0d, level exp %0d got %0d",
                              want.busy, rsp_smoothed_busy, want.level, rsp_load_level);
               end
            end
         end
         if (req_valid && req_ready) begin
            sum_total = TOT_W'(req_user_ticks) + TOT_W'(req_nice_ticks)
                      + TOT_W'(req_system_ticks) + TOT_W'(req_idle_ticks)
                      + TOT_W'(req_iowait_ticks) + TOT_W'(req_irq_ticks)
                      + TOT_W'(req_softirq_ticks) + TOT_W'(req_steal_ticks);
            sum_idle  = IDL_W'(req_idle_ticks) + IDL_W'(req_iowait_ticks);
            track_sample(sum_total, sum_idle, req_force_report);
         end
      end
      error_count   <= mismatches;
      pending_count <= reports_due.size();
   end

endmodule

>>> tb/utilization_ema_hysteresis_level_tb.sv
module utilization_ema_hysteresis_level_tb;
   import uehl_pkg::*;

   localparam int COUNTER_BITS  = 48;
   localparam int FRAC_BITS     = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int SLOT_USER     = 0;
   localparam int SLOT_IDLE     = 3;
   localparam int SLOT_IOWAIT   = 4;
   localparam int SLOT_STEAL    = 7;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam logic [COUNTER_BITS-1:0] CTR_MAX    = '1;

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     csr_valid         = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index         = '0;
   logic [WGT_BITS-1:0]      csr_data          = '0;
   logic                     req_valid         = 1'b0;
   logic                     req_ready;
   logic [COUNTER_BITS-1:0]  req_user_ticks    = '0;
   logic [COUNTER_BITS-1:0]  req_nice_ticks    = '0;
   logic [COUNTER_BITS-1:0]  req_system_ticks  = '0;
   logic [COUNTER_BITS-1:0]  req_idle_ticks    = '0;
   logic [COUNTER_BITS-1:0]  req_iowait_ticks  = '0;
   logic [COUNTER_BITS-1:0]  req_irq_ticks     = '0;
   logic [COUNTER_BITS-1:0]  req_softirq_ticks = '0;
   logic [COUNTER_BITS-1:0]  req_steal_ticks   = '0;
   logic                     req_force_report  = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready         = 1'b0;
   logic [FRAC_BITS+6:0]     rsp_smoothed_busy;
   logic [1:0]               rsp_load_level;
   int                       error_count;
   int                       pending_count;

   logic                     hold_trigger      = 1'b0;
   int                       hold_left         = 0;
   int                       idle_pct          = 0;
   int                       stall_pct         = 0;
   int                       cycles            = 0;
   int                       target            = 50;
   logic [COUNTER_BITS-1:0]  ctr [8];

   utilization_ema_hysteresis_level #(
      .COUNTER_BITS(COUNTER_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_top (.*);

   uehl_checker #(
      .COUNTER_BITS(COUNTER_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_checker (.*);

   always #5 clock = ~clock;

   // receiver: random stalls, or a long hold-off once triggered
   always @(posedge clock) begin
      if (hold_trigger) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("utilization_ema_hysteresis_level_tb: done, errors");
         $finish;
      end
   end

   function automatic logic [COUNTER_BITS-1:0] rand_count();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[COUNTER_BITS-1:0];
   endfunction

   task automatic send_sample(input logic frc);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_user_ticks    <= ctr[0];
      req_nice_ticks    <= ctr[1];
      req_system_ticks  <= ctr[2];
      req_idle_ticks    <= ctr[3];
      req_iowait_ticks  <= ctr[4];
      req_irq_ticks     <= ctr[5];
      req_softirq_ticks <= ctr[6];
      req_steal_ticks   <= ctr[7];
      req_force_report  <= frc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // move the counters forward by a random span split at the given busy percent
   task automatic advance(input int busy_pct, input int span);
      logic [COUNTER_BITS-1:0] total_d;
      logic [COUNTER_BITS-1:0] idle_d;
      logic [COUNTER_BITS-1:0] busy_d;
      logic [COUNTER_BITS-1:0] part;
      int                      i;
      total_d = rand_count() >> (COUNTER_BITS - span);
      if (total_d == 0) total_d = 1;
      idle_d = total_d * COUNTER_BITS'(100 - busy_pct) / COUNTER_BITS'(100);
      part   = rand_count() % (idle_d + 1);
      ctr[SLOT_IDLE]   += part;
      ctr[SLOT_IOWAIT] += idle_d - part;
      busy_d = total_d - idle_d;
      for (i = 0; i < 8; i++) begin
         if (i != SLOT_IDLE && i != SLOT_IOWAIT) begin
            part = (i == SLOT_STEAL) ? busy_d : rand_count() % (busy_d + 1);
            ctr[i] += part;
            busy_d -= part;
         end
      end
   endtask

   // idle jumps while user time steps back: idle delta exceeds total delta
   task automatic idle_surge();
      logic [COUNTER_BITS-1:0] surge;
      logic [COUNTER_BITS-1:0] keep;
      surge = COUNTER_BITS'($urandom_range(100000, 1000));
      keep  = COUNTER_BITS'($urandom_range(500, 1));
      ctr[SLOT_IDLE] += surge;
      ctr[SLOT_USER] -= surge - keep;
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [WGT_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic configure(input int idle, input int stall,
                            input logic [WGT_BITS-1:0] u_mid, input logic [WGT_BITS-1:0] u_warn,
                            input logic [WGT_BITS-1:0] u_crit, input logic [WGT_BITS-1:0] d_crit,
                            input logic [WGT_BITS-1:0] d_warn, input logic [WGT_BITS-1:0] d_mid,
                            input logic [WGT_BITS-1:0] wgt);
      drain();
      // samples without a result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_UP_TO_MID, u_mid);
      csr_write(CSR_UP_TO_WARNING, u_warn);
      csr_write(CSR_UP_TO_CRITICAL, u_crit);
      csr_write(CSR_DOWN_FROM_CRITICAL, d_crit);
      csr_write(CSR_DOWN_FROM_WARNING, d_warn);
      csr_write(CSR_DOWN_FROM_MID, d_mid);
      csr_write(CSR_SMOOTHING_WEIGHT, wgt);
      csr_write(CSR_UNUSED, WGT_BITS'($urandom));
      csr_valid <= 1'b0;
      idle_pct  = idle;
      stall_pct <= stall;
   endtask

   task automatic send_mix(input int n);
      int r;
      int i;
      repeat (n) begin
         r = $urandom_range(99);
         if ($urandom_range(9) == 0) begin
            target = $urandom_range(100);
         end else begin
            target += int'($urandom_range(10)) - 5;
            if (target < 0) target = 0;
            if (target > 100) target = 100;
         end
         if (r < 78) begin
            advance(target, $urandom_range(40, 4));
         end else if (r < 84) begin
            // counters unchanged: no elapsed ticks
         end else if (r < 89) begin
            idle_surge();
         end else if (r < 93) begin
            for (i = 0; i < 8; i++) ctr[i] = rand_count();
         end else if (r < 96) begin
            // park near the top so the next transfers wrap
            for (i = 0; i < 8; i++) ctr[i] = CTR_MAX - COUNTER_BITS'($urandom_range(1000));
         end else begin
            advance((r < 98) ? 100 : 0, $urandom_range(30, 4));
         end
         send_sample($urandom_range(9) == 0);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) ctr[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, registers at their reset values
      send_sample(1'b0);
      send_sample(1'b0);
      advance(100, 12);
      send_sample(1'b0);
      repeat (3) begin
         advance(0, 12);
         send_sample(1'b0);
      end
      idle_surge();
      send_sample(1'b0);
      advance(50, 20);
      send_sample(1'b1);
      send_sample(1'b1);
      for (int i = 0; i < 8; i++) ctr[i] = CTR_MAX;
      send_sample(1'b1);
      advance(60, 24);
      send_sample(1'b1);
      for (int i = 0; i < 8; i++) ctr[i] = '0;
      send_sample(1'b0);
      advance(100, 40);
      send_sample(1'b0);
      advance(100, 1);
      send_sample(1'b0);
      advance(37, 33);
      send_sample(1'b1);
      advance(1, 16);
      send_sample(1'b0);
      advance(99, 16);
      send_sample(1'b1);

      configure(0, 0, 9'd30, 9'd65, 9'd85, 9'd75, 9'd55, 9'd20, 9'd256);
      send_mix(40);
      // long receiver hold-off while forced samples keep coming
      req_valid    <= 1'b0;
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      repeat (12) begin
         advance(target, 20);
         send_sample(1'b1);
      end
      send_mix(40);

      configure(57, 0, 9'd0, 9'd0, 9'd0, 9'd127, 9'd127, 9'd127, 9'd0);
      send_mix(85);

      configure(0, 57, 9'h1FF, 9'h17F, 9'd127, 9'd0, 9'd0, 9'd0, 9'd511);
      send_mix(40);
      drain();
      send_mix(45);

      configure(35, 35, 9'd50, 9'd70, 9'd90, 9'd40, 9'd60, 9'd10, 9'd128);
      send_mix(85);

      configure(0, 0, 9'd10, 9'd20, 9'd30, 9'd5, 9'd15, 9'd25, 9'd1);
      send_mix(85);

      configure(57, 0, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd100, 9'd255);
      send_mix(85);

      configure(0, 57, WGT_BITS'($urandom_range(100)), WGT_BITS'($urandom_range(100)),
                WGT_BITS'($urandom_range(100)), WGT_BITS'($urandom_range(100)),
                WGT_BITS'($urandom_range(100)), WGT_BITS'($urandom_range(100)),
                WGT_BITS'($urandom_range(511)));
      send_mix(85);

      configure(35, 35, 9'd30, 9'd65, 9'd85, 9'd75, 9'd55, 9'd20, 9'd64);
      send_mix(85);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("utilization_ema_hysteresis_level_tb: done, clean");
      end else begin
         $display("utilization_ema_hysteresis_level_tb: done, errors");
      end
      $finish;
   end

endmodule
